>>> rtl/bgbc_pkg.sv
// Shared types and constants for the binary grid boundary cell counter.
package bgbc_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int CODE_W      = 8;
   localparam int COUNT_W     = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 1'd1;

   localparam logic [CODE_W-1:0] WATER_CODE = 8'd46;

   typedef struct packed {
      logic upper_land;
      logic middle_land;
   } cell_bits_type;

   typedef struct packed {
      logic shift;
      logic land;
   } push_type;

   typedef struct packed {
      logic upper_land;
      logic middle_land;
      logic right_land;
   } tap_type;

endpackage

>>> rtl/binary_grid_boundary_cell_counter.sv
// Top level of the binary grid boundary cell counter.
//
// Counts the coast cells of a map grid streamed in raster order, one cell code per item:
// code 46 is water, any other code is land, and a land cell is coast when it lies on the
// grid border or has water directly above, below, left or right. The block takes one item
// every clock cycle; a cell of an inner row is decided when the cell below it arrives, by
// reading a chain of MAX_COLUMNS column cells that acts as two one-bit line stores whose
// length follows column_count. The result item carrying the total appears in the cycle after
// the final cell of the grid is accepted and is held in an output register; while it waits
// with rsp_ready low, req_ready is held low and input stalls. Writing row_count or
// column_count restarts the grid; values of zero are taken as one and values above the
// bounds are taken as the bounds.
module binary_grid_boundary_cell_counter #(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bgbc_pkg::CODE_W-1:0]         req_cell_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bgbc_pkg::COUNT_W-1:0]        rsp_coast_count,
   input  logic                                csr_we,
   input  logic [bgbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bgbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int COUNT_W = bgbc_pkg::COUNT_W;

   logic [RCNT_W-1:0]  row_count_ff, row_count_in;
   logic [CCNT_W-1:0]  col_count_ff, col_count_in;
   logic [COL_W-1:0]   col_entry_ff, col_entry_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               left_mid_ff, left_mid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               accept;
   logic               cur_land;
   logic               row_nonzero;
   logic               last_col;
   logic               last_row;
   logic               mid_coast;
   logic               grid_done;
   logic [COUNT_W-1:0] total_sum;
   logic [31:0]        wdata_wide;
   logic [31:0]        row_clamp;
   logic [31:0]        col_clamp;
   logic [31:0]        entry_wide;

   bgbc_pkg::push_type push;
   bgbc_pkg::tap_type  taps;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cur_land  = (req_cell_code != bgbc_pkg::WATER_CODE);

   assign push.shift = accept;
   assign push.land  = cur_land;

   bgbc_line_chain #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .COL_W       (COL_W)
   ) u_line_chain (
      .clock       (clock),
      .push        (push),
      .entry_index (col_entry_ff),
      .taps        (taps)
   );

   assign row_nonzero = (row_ff != '0);
   assign last_col    = ((CCNT_W'(col_ff) + CCNT_W'(1)) == col_count_ff);
   assign last_row    = ((RCNT_W'(row_ff) + RCNT_W'(1)) == row_count_ff);
   assign grid_done   = last_col && last_row;

   assign mid_coast = row_nonzero && taps.middle_land &&
                      ((row_ff == ROW_W'(1)) || (col_ff == '0) || last_col ||
                       !taps.upper_land || !left_mid_ff || !taps.right_land || !cur_land);

   assign total_sum = total_ff + COUNT_W'(mid_coast) + COUNT_W'(last_row && cur_land);

   always_comb begin
      wdata_wide = 32'(csr_wdata);
      if (wdata_wide == 32'd0) begin
         row_clamp = 32'd1;
      end else if (wdata_wide > 32'(MAX_ROWS)) begin
         row_clamp = 32'(MAX_ROWS);
      end else begin
         row_clamp = wdata_wide;
      end
      if (wdata_wide == 32'd0) begin
         col_clamp = 32'd1;
      end else if (wdata_wide > 32'(MAX_COLUMNS)) begin
         col_clamp = 32'(MAX_COLUMNS);
      end else begin
         col_clamp = wdata_wide;
      end
      entry_wide = 32'(MAX_COLUMNS) - col_clamp;
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      col_entry_in = col_entry_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      total_in     = total_ff;
      left_mid_in  = left_mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            bgbc_pkg::CSR_ROW_COUNT: begin
               row_count_in = row_clamp[RCNT_W-1:0];
            end
            bgbc_pkg::CSR_COLUMN_COUNT: begin
               col_count_in = col_clamp[CCNT_W-1:0];
               col_entry_in = entry_wide[COL_W-1:0];
            end
            default: begin
            end
         endcase
         row_in      = '0;
         col_in      = '0;
         total_in    = '0;
         left_mid_in = 1'b0;
      end else if (accept) begin
         if (row_nonzero) begin
            left_mid_in = taps.middle_land;
         end
         total_in = total_sum;
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in       = '0;
               total_in     = '0;
               left_mid_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_count_in = total_sum;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RCNT_W'(1);
         col_count_ff <= CCNT_W'(1);
         col_entry_ff <= COL_W'(MAX_COLUMNS - 1);
         row_ff       <= '0;
         col_ff       <= '0;
         total_ff     <= '0;
         left_mid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         col_entry_ff <= col_entry_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         total_ff     <= total_in;
         left_mid_ff  <= left_mid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coast_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CCNT_W'(col_ff) < col_count_ff)
      else $error("Column position is outside the configured width.");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      RCNT_W'(row_ff) < row_count_ff)
      else $error("Row position is outside the configured height.");

   a_rsp_after_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && grid_done))
      else $error("A result appeared without a finished grid.");

   a_restart_after_grid: assert property (@(posedge clock) disable iff (reset)
      (accept && grid_done && !csr_we) |=> (total_ff == '0 && row_ff == '0 && col_ff == '0))
      else $error("The grid did not restart after its final item.");
`endif

endmodule

>>> rtl/bgbc_cell.sv
// One column cell of the line chain: holds the upper and middle row land flags.
module bgbc_cell (
   input  logic                    clock,
   input  logic                    shift,
   input  logic                    is_entry,
   input  bgbc_pkg::cell_bits_type entry_bits,
   input  bgbc_pkg::cell_bits_type left_bits,
   output bgbc_pkg::cell_bits_type bits
);

   bgbc_pkg::cell_bits_type bits_ff;
   bgbc_pkg::cell_bits_type bits_in;

   always_comb begin
      bits_in = bits_ff;
      if (shift) begin
         bits_in = is_entry ? entry_bits : left_bits;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

   assign bits = bits_ff;

endmodule

>>> rtl/bgbc_line_chain.sv
// Chain of column cells forming the two line stores with a configurable entry point.
module bgbc_line_chain #(
   parameter int MAX_COLUMNS = 1024,
   parameter int COL_W       = 10
) (
   input  logic                 clock,
   input  bgbc_pkg::push_type   push,
   input  logic [COL_W-1:0]     entry_index,
   output bgbc_pkg::tap_type    taps
);

   bgbc_pkg::cell_bits_type cell_bits [MAX_COLUMNS];
   bgbc_pkg::cell_bits_type entry_bits;

   assign entry_bits.upper_land  = cell_bits[MAX_COLUMNS-1].middle_land;
   assign entry_bits.middle_land = push.land;

   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
      if (i == 0) begin : g_first
         bgbc_cell u_cell (
            .clock      (clock),
            .shift      (push.shift),
            .is_entry   (entry_index == COL_W'(i)),
            .entry_bits (entry_bits),
            .left_bits  (entry_bits),
            .bits       (cell_bits[i])
         );
      end else begin : g_rest
         bgbc_cell u_cell (
            .clock      (clock),
            .shift      (push.shift),
            .is_entry   (entry_index == COL_W'(i)),
            .entry_bits (entry_bits),
            .left_bits  (cell_bits[i-1]),
            .bits       (cell_bits[i])
         );
      end
   end

   assign taps.upper_land  = cell_bits[MAX_COLUMNS-1].upper_land;
   assign taps.middle_land = cell_bits[MAX_COLUMNS-1].middle_land;

   if (MAX_COLUMNS >= 2) begin : g_right
      assign taps.right_land = cell_bits[MAX_COLUMNS-2].middle_land;
   end else begin : g_no_right
      assign taps.right_land = 1'b1;
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the binary grid boundary cell counter.
module tb_top;

   localparam int GRID_MAX     = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DIRECTED_LEN = 29;

   typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_type;

   typedef struct packed {
      step_kind_type                      kind;
      logic [bgbc_pkg::CSR_INDEX_W-1:0]   index;
      logic [bgbc_pkg::CSR_DATA_W-1:0]    value;
      logic [bgbc_pkg::CODE_W-1:0]        code;
      logic                               typed;
      logic [bgbc_pkg::COUNT_W-1:0]       total;
   } directed_step_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [bgbc_pkg::CODE_W-1:0]       req_cell_code = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [bgbc_pkg::COUNT_W-1:0]      rsp_coast_count;
   logic                              csr_we = 1'b0;
   logic [bgbc_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [bgbc_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned cells_sent = 0;
   int unsigned writes_done = 0;
   int unsigned totals_checked = 0;

   // Predicted grid state.
   int unsigned                  rows_in_use = 1;
   int unsigned                  cols_in_use = 1;
   bit                           upper_land [GRID_MAX];
   bit                           middle_land [GRID_MAX];
   int unsigned                  row_pos = 0;
   int unsigned                  col_pos = 0;
   logic [bgbc_pkg::COUNT_W-1:0] coast_total = '0;
   bit                           left_land = 1'b0;

   logic [bgbc_pkg::COUNT_W-1:0] expected_totals [$];
   logic [bgbc_pkg::COUNT_W-1:0] oldest_total;

   directed_step_type directed_steps [DIRECTED_LEN] = '{
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd0,   1'b1, 21'd1},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd46,  1'b1, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd255, 1'b1, 21'd1},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd45,  1'b1, 21'd1},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd47,  1'b1, 21'd1},
      '{STEP_WRITE, bgbc_pkg::CSR_COLUMN_COUNT, 11'd3, 8'd0,   1'b0, 21'd0},
      '{STEP_WRITE, bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd0,   1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd46,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd170, 1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd46,  1'b1, 21'd1},
      '{STEP_WRITE, bgbc_pkg::CSR_ROW_COUNT,    11'd3, 8'd0,   1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd85,  1'b1, 21'd8},
      '{STEP_WRITE, bgbc_pkg::CSR_ROW_COUNT,    11'd2, 8'd0,   1'b0, 21'd0},
      '{STEP_WRITE, bgbc_pkg::CSR_COLUMN_COUNT, 11'd2, 8'd0,   1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd1,   1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd2,   1'b0, 21'd0},
      '{STEP_WRITE, bgbc_pkg::CSR_COLUMN_COUNT, 11'd2, 8'd0,   1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd65,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd65,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd65,  1'b0, 21'd0},
      '{STEP_CELL,  bgbc_pkg::CSR_ROW_COUNT,    11'd0, 8'd46,  1'b1, 21'd3}
   };

   binary_grid_boundary_cell_counter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_code   (req_cell_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coast_count (rsp_coast_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_size(input logic [bgbc_pkg::CSR_DATA_W-1:0] value);
      if (value == 0) return 1;
      if (value > GRID_MAX) return GRID_MAX;
      return value;
   endfunction

   function automatic void restart_count();
      row_pos = 0;
      col_pos = 0;
      coast_total = '0;
      left_land = 1'b0;
   endfunction

   function automatic void apply_size_write(input logic [bgbc_pkg::CSR_INDEX_W-1:0] index,
                                            input logic [bgbc_pkg::CSR_DATA_W-1:0] value);
      case (index)
         bgbc_pkg::CSR_ROW_COUNT: begin
            rows_in_use = clamp_size(value);
         end
         bgbc_pkg::CSR_COLUMN_COUNT: begin
            cols_in_use = clamp_size(value);
         end
         default: begin
         end
      endcase
      restart_count();
   endfunction

   // A cell of an inner row is decided when the cell below it arrives; the last row
   // counts its land cells on arrival.
   function automatic bit advance_cell(input logic [bgbc_pkg::CODE_W-1:0] code,
                                       output logic [bgbc_pkg::COUNT_W-1:0] total);
      int unsigned c;
      int unsigned r;
      bit          land;
      bit          above;
      c = col_pos;
      r = row_pos;
      land = (code != bgbc_pkg::WATER_CODE);
      total = '0;
      if (c >= cols_in_use) c = 0;
      if (r >= 1) begin
         above = middle_land[c];
         if (above && (r == 1 || c == 0 || c + 1 >= cols_in_use || !upper_land[c]
                       || !left_land || !middle_land[c + 1] || !land))
            coast_total = coast_total + 1'b1;
         left_land = above;
         upper_land[c] = above;
      end
      middle_land[c] = land;
      if (r + 1 >= rows_in_use && land) coast_total = coast_total + 1'b1;
      if (c + 1 >= cols_in_use) begin
         col_pos = 0;
         if (r + 1 >= rows_in_use) begin
            total = coast_total;
            restart_count();
            return 1'b1;
         end
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      return 1'b0;
   endfunction

   function automatic logic [bgbc_pkg::CODE_W-1:0] random_code(input int unsigned land_pct);
      logic [bgbc_pkg::CODE_W-1:0] code;
      if ($urandom_range(99) >= land_pct) return bgbc_pkg::WATER_CODE;
      code = bgbc_pkg::CODE_W'($urandom_range(255));
      while (code == bgbc_pkg::WATER_CODE) code = bgbc_pkg::CODE_W'($urandom_range(255));
      return code;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[cycle %0d] mismatch: %s", cycle_count, what);
   endtask

   task automatic send_cell(input logic [bgbc_pkg::CODE_W-1:0] code, input bit typed,
                            input logic [bgbc_pkg::COUNT_W-1:0] total);
      logic [bgbc_pkg::COUNT_W-1:0] predicted;
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cell_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_sent++;
      if (advance_cell(code, predicted)) expected_totals.push_back(typed ? total : predicted);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input logic [bgbc_pkg::CSR_INDEX_W-1:0] index,
                             input logic [bgbc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_size_write(index, value);
      writes_done++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_grids(input int unsigned target);
      int unsigned sent_here;
      int unsigned rows;
      int unsigned cols;
      int unsigned grids;
      int unsigned cells;
      int unsigned land_pct;
      sent_here = 0;
      while (sent_here < target) begin
         if ($urandom_range(9) == 0) begin
            rows = $urandom_range(1, 12);
            cols = $urandom_range(1, 12);
         end else begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 6);
         end
         wait_for_idle();
         write_size(bgbc_pkg::CSR_ROW_COUNT, bgbc_pkg::CSR_DATA_W'(rows));
         write_size(bgbc_pkg::CSR_COLUMN_COUNT, bgbc_pkg::CSR_DATA_W'(cols));
         grids = $urandom_range(1, 3);
         for (int g = 0; g < grids; g++) begin
            cells = rows * cols;
            // A broken grid is cut short and dropped by the next size write.
            if (g == grids - 1 && cells > 1 && $urandom_range(15) == 0)
               cells = $urandom_range(cells - 1);
            land_pct = $urandom_range(100);
            for (int i = 0; i < cells; i++) send_cell(random_code(land_pct), 1'b0, '0);
            sent_here += cells;
            if ($urandom_range(39) == 0) wait_for_idle();
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            report_mismatch($sformatf("unexpected result, coast_count %0d", rsp_coast_count));
         end else begin
            oldest_total = expected_totals.pop_front();
            totals_checked++;
            if (rsp_coast_count !== oldest_total)
               report_mismatch($sformatf("coast_count %0d, expected %0d",
                                         rsp_coast_count, oldest_total));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d totals outstanding.",
                  cycle_count, expected_totals.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned idle_table [4];
      int unsigned stall_table [4];
      idle_table = '{0, 81, 0, 16};
      stall_table = '{0, 0, 81, 16};
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            wait_for_idle();
            write_size(directed_steps[i].index, directed_steps[i].value);
         end else begin
            send_cell(directed_steps[i].code, directed_steps[i].typed, directed_steps[i].total);
         end
      end

      for (int p = 0; p < 4; p++) begin
         wait_for_idle();
         send_idle_pct = idle_table[p];
         stall_pct = stall_table[p];
         run_grids(150);
      end

      // Full width in one row, with out-of-range sizes.
      wait_for_idle();
      write_size(bgbc_pkg::CSR_ROW_COUNT, '0);
      write_size(bgbc_pkg::CSR_COLUMN_COUNT, '1);
      for (int i = 0; i < GRID_MAX; i++) send_cell(random_code(70), 1'b0, '0);

      wait_for_idle();
      repeat (16) @(posedge clock);
      $display("Checked %0d grid totals from %0d cells and %0d size writes.",
               totals_checked, cells_sent, writes_done);
      $display("Grids ran from 1x1 to 12x12 and one full-width row under sender gaps and stalls.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
